// File: design/rsnp_pkg.sv
// ----------------------------------------------------------------------------
// rsnp_pkg - shared types and constants for the ray/sphere nearest pick
// Field widths, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rsnp_pkg;

    localparam int POS_W   = 24;
    localparam int DIR_W   = 14;
    localparam int RAD_W   = 23;
    localparam int ID_W    = 16;
    localparam int DIST_W  = 52;
    localparam int V_W     = POS_W + 1;
    localparam int OP_W    = 26;
    localparam int PROD_W  = 2 * OP_W;
    localparam int DOT_W   = 40;
    localparam int C_W     = DIST_W + 1;
    localparam int SPLIT   = 20;
    localparam int DISC_W  = 2 * DOT_W;
    localparam int FRAC_SH = 24;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;

    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 14'sd4096;

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [POS_W-1:0] origin_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
        logic [RAD_W-1:0]        radius;
        logic [ID_W-1:0]         object_id;
        logic                    last_sphere;
    } t_item;

    typedef struct packed {
        logic hit_found;
        logic [ID_W-1:0]   best_id;
        logic [DIST_W-1:0] best_dist_sq;
    } t_result;

    typedef struct packed {
        logic load;
        logic sq;
        logic dot;
        logic rr;
        logic csq;
        logic sum;
        logic upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

// File: design/rsnp_cfg.sv
// ----------------------------------------------------------------------------
// rsnp_cfg - configuration register bank
// Holds the pick ray origin and direction behind an APB-style port.
// ----------------------------------------------------------------------------
module rsnp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsnp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output rsnp_pkg::t_cfg              o_cfg
);

    rsnp_pkg::t_cfg                r_cfg;
    logic                          w_wr;
    logic [rsnp_pkg::IDX_W-1:0]    w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[rsnp_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.origin_z <= '0;
            r_cfg.dir_x    <= '0;
            r_cfg.dir_y    <= '0;
            r_cfg.dir_z    <= rsnp_pkg::DIR_Z_RESET;
        end else if (w_wr) begin
            case (w_idx)
                rsnp_pkg::REG_ORIGIN_X: r_cfg.origin_x <= pwdata[rsnp_pkg::POS_W-1:0];
                rsnp_pkg::REG_ORIGIN_Y: r_cfg.origin_y <= pwdata[rsnp_pkg::POS_W-1:0];
                rsnp_pkg::REG_ORIGIN_Z: r_cfg.origin_z <= pwdata[rsnp_pkg::POS_W-1:0];
                rsnp_pkg::REG_DIR_X:    r_cfg.dir_x    <= pwdata[rsnp_pkg::DIR_W-1:0];
                rsnp_pkg::REG_DIR_Y:    r_cfg.dir_y    <= pwdata[rsnp_pkg::DIR_W-1:0];
                rsnp_pkg::REG_DIR_Z:    r_cfg.dir_z    <= pwdata[rsnp_pkg::DIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rsnp_pkg::REG_ORIGIN_X: prdata = 32'(r_cfg.origin_x);
            rsnp_pkg::REG_ORIGIN_Y: prdata = 32'(r_cfg.origin_y);
            rsnp_pkg::REG_ORIGIN_Z: prdata = 32'(r_cfg.origin_z);
            rsnp_pkg::REG_DIR_X:    prdata = 32'(r_cfg.dir_x);
            rsnp_pkg::REG_DIR_Y:    prdata = 32'(r_cfg.dir_y);
            rsnp_pkg::REG_DIR_Z:    prdata = 32'(r_cfg.dir_z);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/rsnp_ctrl.sv
// ----------------------------------------------------------------------------
// rsnp_ctrl - sequencer for the sphere test
// Steps the datapath through squares, dot products, discriminant and update,
// and owns the request handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module rsnp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rsnp_pkg::t_sts i_sts,
    output rsnp_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_RR   = 3'd3;
    localparam logic [2:0] S_CSQ  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_upd_go;
    logic       w_fire;

    assign w_upd_go   = (r_state == S_UPD) && (!i_sts.last || !r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_upd_go;
    assign w_fire     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_fire) n_state = S_SQ;
            S_SQ:   n_state = S_DOT;
            S_DOT:  n_state = S_RR;
            S_RR:   n_state = S_CSQ;
            S_CSQ:  n_state = S_SUM;
            S_SUM:  n_state = S_UPD;
            S_UPD: begin
                if (w_upd_go) n_state = w_fire ? S_SQ : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load = w_fire;
        o_cmd.sq   = (r_state == S_SQ);
        o_cmd.dot  = (r_state == S_DOT);
        o_cmd.rr   = (r_state == S_RR);
        o_cmd.csq  = (r_state == S_CSQ);
        o_cmd.sum  = (r_state == S_SUM);
        o_cmd.upd  = w_upd_go;
        o_cmd.emit = w_upd_go && i_sts.last;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_upd_go && i_sts.last) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: design/rsnp_dp.sv
// ----------------------------------------------------------------------------
// rsnp_dp - arithmetic for the sphere test and nearest-hit tracking
// Three multiplier lanes, shared over the squares, the dot product, r^2 and
// the split square of the dot product; running minimum and result register.
// ----------------------------------------------------------------------------
module rsnp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsnp_pkg::t_cfg    i_cfg,
    input  rsnp_pkg::t_item   i_item,
    input  rsnp_pkg::t_cmd    i_cmd,
    output rsnp_pkg::t_sts    o_sts,
    output rsnp_pkg::t_result o_result
);

    localparam int OP_W   = rsnp_pkg::OP_W;
    localparam int V_W    = rsnp_pkg::V_W;
    localparam int DOT_W  = rsnp_pkg::DOT_W;
    localparam int DIST_W = rsnp_pkg::DIST_W;
    localparam int C_W    = rsnp_pkg::C_W;
    localparam int DISC_W = rsnp_pkg::DISC_W;
    localparam int SPLIT  = rsnp_pkg::SPLIT;

    logic signed [V_W-1:0]               r_vx, r_vy, r_vz;
    logic [rsnp_pkg::RAD_W-1:0]          r_rad;
    logic [rsnp_pkg::ID_W-1:0]           r_id;
    logic                                r_last;
    logic signed [rsnp_pkg::PROD_W-1:0]  r_p [3];
    logic [DIST_W-1:0]                   r_vv;
    logic signed [DOT_W-1:0]             r_dot;
    logic signed [C_W-1:0]               r_c;
    logic [DISC_W-1:0]                   r_disc;
    logic                                r_have;
    logic [DIST_W-1:0]                   r_min_d;
    logic [rsnp_pkg::ID_W-1:0]           r_min_id;
    rsnp_pkg::t_result                   r_result;

    logic signed [OP_W-1:0]              w_a [3];
    logic signed [OP_W-1:0]              w_b [3];
    logic [DOT_W-1:0]                    w_mag;
    logic [DOT_W-SPLIT-1:0]              w_hi;
    logic [SPLIT-1:0]                    w_lo;
    logic                                w_c_pos;
    logic                                w_dot_pos;
    logic [DISC_W-1:0]                   w_c_sh;
    logic                                w_hit;
    logic                                w_take;
    logic                                n_have;
    logic [DIST_W-1:0]                   n_min_d;
    logic [rsnp_pkg::ID_W-1:0]           n_min_id;

    assign w_mag = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);
    assign w_hi  = w_mag[DOT_W-1:SPLIT];
    assign w_lo  = w_mag[SPLIT-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = '0;
            w_b[i] = '0;
        end
        if (i_cmd.sq) begin
            w_a[0] = OP_W'(r_vx);  w_b[0] = OP_W'(r_vx);
            w_a[1] = OP_W'(r_vy);  w_b[1] = OP_W'(r_vy);
            w_a[2] = OP_W'(r_vz);  w_b[2] = OP_W'(r_vz);
        end else if (i_cmd.dot) begin
            w_a[0] = OP_W'(r_vx);  w_b[0] = OP_W'(i_cfg.dir_x);
            w_a[1] = OP_W'(r_vy);  w_b[1] = OP_W'(i_cfg.dir_y);
            w_a[2] = OP_W'(r_vz);  w_b[2] = OP_W'(i_cfg.dir_z);
        end else if (i_cmd.rr) begin
            w_a[0] = $signed(OP_W'(r_rad));
            w_b[0] = $signed(OP_W'(r_rad));
        end else if (i_cmd.csq) begin
            w_a[0] = $signed(OP_W'(w_hi));  w_b[0] = $signed(OP_W'(w_hi));
            w_a[1] = $signed(OP_W'(w_hi));  w_b[1] = $signed(OP_W'(w_lo));
            w_a[2] = $signed(OP_W'(w_lo));  w_b[2] = $signed(OP_W'(w_lo));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p[i] <= w_a[i] * w_b[i];
        end
        if (i_cmd.load) begin
            r_vx   <= V_W'(i_cfg.origin_x) - V_W'(i_item.center_x);
            r_vy   <= V_W'(i_cfg.origin_y) - V_W'(i_item.center_y);
            r_vz   <= V_W'(i_cfg.origin_z) - V_W'(i_item.center_z);
            r_rad  <= i_item.radius;
            r_id   <= i_item.object_id;
            r_last <= i_item.last_sphere;
        end
        if (i_cmd.dot) begin
            r_vv <= DIST_W'($unsigned(r_p[0])) + DIST_W'($unsigned(r_p[1]))
                  + DIST_W'($unsigned(r_p[2]));
        end
        if (i_cmd.rr) begin
            r_dot <= DOT_W'(r_p[0]) + DOT_W'(r_p[1]) + DOT_W'(r_p[2]);
        end
        if (i_cmd.csq) begin
            r_c <= $signed({1'b0, r_vv}) - C_W'(r_p[0]);
        end
        if (i_cmd.sum) begin
            r_disc <= (DISC_W'(r_p[0][2*SPLIT-1:0]) << (2 * SPLIT))
                    + (DISC_W'(r_p[1][2*SPLIT-1:0]) << (SPLIT + 1))
                    + DISC_W'(r_p[2][2*SPLIT-1:0]);
        end
        if (i_cmd.emit) begin
            r_result.hit_found    <= n_have;
            r_result.best_id      <= n_have ? n_min_id : '0;
            r_result.best_dist_sq <= n_have ? n_min_d : '0;
        end
    end

    assign w_c_pos   = !r_c[C_W-1] && (r_c != '0);
    assign w_dot_pos = !r_dot[DOT_W-1] && (r_dot != '0);
    assign w_c_sh    = DISC_W'(r_c[C_W-2:0]) << rsnp_pkg::FRAC_SH;
    assign w_hit     = !w_c_pos || (!w_dot_pos && (r_disc >= w_c_sh));
    assign w_take    = w_hit && (!r_have || (r_vv <= r_min_d));

    always_comb begin
        n_have   = r_have;
        n_min_d  = r_min_d;
        n_min_id = r_min_id;
        if (w_take) begin
            n_have   = 1'b1;
            n_min_d  = r_vv;
            n_min_id = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_min_d  <= '0;
            r_min_id <= '0;
        end else if (i_cmd.upd) begin
            if (r_last) begin
                r_have   <= 1'b0;
                r_min_d  <= '0;
                r_min_id <= '0;
            end else begin
                r_have   <= n_have;
                r_min_d  <= n_min_d;
                r_min_id <= n_min_id;
            end
        end
    end

    assign o_sts.last = r_last;
    assign o_result   = r_result;

endmodule

// File: design/ray_sphere_nearest_pick_top.sv
// ----------------------------------------------------------------------------
// ray_sphere_nearest_pick_top - nearest sphere hit along a pick ray
// Streams spheres against a configured ray and reports the nearest hit.
//
//   channel   group    width         role
//   spheres   s_axis   112 + tlast   sphere requests in
//   result    m_axis   72  + tuser   one result per query out
//   config    apb      32            ray origin and direction
//
// A sphere steps through the squares, the dot product, r^2 and the split square on
// the three shared multiplier lanes, then the sum and the update; a new sphere is
// taken in the update cycle of the previous one, and the result is loaded in the
// update of the last sphere. Reset is synchronous and returns the ray to origin 0 and
// direction +z. A held result stalls only the update of the next last sphere.
// ----------------------------------------------------------------------------
module ray_sphere_nearest_pick_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_x[23:0], center_y[47:24], center_z[71:48], radius[94:72],
    // object_id[110:95], zero[111]
    input  logic [111:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // best_id[15:0], best_dist_sq[67:16], zero[71:68]
    output logic [71:0] m_axis_tdata,
    // hit_found[0]
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rsnp_pkg::t_cfg    w_cfg;
    rsnp_pkg::t_item   w_item;
    rsnp_pkg::t_cmd    w_cmd;
    rsnp_pkg::t_sts    w_sts;
    rsnp_pkg::t_result w_result;

    assign pready = 1'b1;

    assign w_item.center_x    = s_axis_tdata[23:0];
    assign w_item.center_y    = s_axis_tdata[47:24];
    assign w_item.center_z    = s_axis_tdata[71:48];
    assign w_item.radius      = s_axis_tdata[94:72];
    assign w_item.object_id   = s_axis_tdata[110:95];
    assign w_item.last_sphere = s_axis_tlast;

    rsnp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    rsnp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rsnp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (w_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

    assign m_axis_tdata = {4'b0, w_result.best_dist_sq, w_result.best_id};
    assign m_axis_tuser = w_result.hit_found;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sphere request taken while the test is in progress");

    a_busy_whole_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##5 !s_axis_tready)
        else $error("sphere request taken before the update cycle");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 72'd0)
        else $error("result without hit carries a non-zero id or distance");

    a_emit_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.last && w_cmd.upd)
        else $error("result loaded outside the update of a last sphere");
`endif

endmodule

// File: verif/rsnp_pick_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsnp_pick_checker - nearest-pick prediction and result scoreboard
// Tracks the ray from APB writes and predicts each query's nearest sphere hit
// from the sphere requests it sees on the input stream. Each result on the
// output stream is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rsnp_pick_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_sph_valid,
    input  logic         i_sph_ready,
    input  logic [111:0] i_sph_data,
    input  logic         i_sph_last,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [71:0]  i_res_data,
    input  logic         i_res_user,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [4:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_results,
    output int           o_hits
);

    rsnp_pkg::t_cfg              ray;
    logic                        run_hit;
    logic [rsnp_pkg::DIST_W-1:0] run_dist;
    logic [rsnp_pkg::ID_W-1:0]   run_id;
    rsnp_pkg::t_result           expected_picks [$];
    int                          errors  = 0;
    int                          results = 0;
    int                          hits    = 0;

    assign o_errors  = errors;
    assign o_pending = expected_picks.size();
    assign o_results = results;
    assign o_hits    = hits;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("%0t ns: pick mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
    endtask

    // exact ray test: hit when some root of the quadratic is not negative
    function automatic logic sphere_hit(input rsnp_pkg::t_cfg r, input rsnp_pkg::t_item s,
                                        output logic [rsnp_pkg::DIST_W-1:0] dist_sq);
        longint              vx, vy, vz, dot, vv, rr, c;
        logic signed [127:0] dot_w, c_w;
        vx  = longint'($signed(r.origin_x)) - longint'($signed(s.center_x));
        vy  = longint'($signed(r.origin_y)) - longint'($signed(s.center_y));
        vz  = longint'($signed(r.origin_z)) - longint'($signed(s.center_z));
        rr  = longint'(s.radius);
        dot = longint'($signed(r.dir_x)) * vx + longint'($signed(r.dir_y)) * vy
            + longint'($signed(r.dir_z)) * vz;
        vv  = vx * vx + vy * vy + vz * vz;
        c   = vv - rr * rr;
        dist_sq = vv[rsnp_pkg::DIST_W-1:0];
        if (c <= 0)
            return 1'b1;
        if (dot > 0)
            return 1'b0;
        dot_w = 128'(dot);
        c_w   = 128'(c);
        return (dot_w * dot_w) >= (c_w <<< rsnp_pkg::FRAC_SH);
    endfunction

    task automatic predict_sphere(input rsnp_pkg::t_item s);
        logic [rsnp_pkg::DIST_W-1:0] d;
        rsnp_pkg::t_result           pick;
        if (sphere_hit(ray, s, d) && (!run_hit || d <= run_dist)) begin
            run_hit  = 1'b1;
            run_dist = d;
            run_id   = s.object_id;
        end
        if (s.last_sphere) begin
            pick.hit_found    = run_hit;
            pick.best_id      = run_id;
            pick.best_dist_sq = run_dist;
            expected_picks.push_back(pick);
            run_hit  = 1'b0;
            run_dist = '0;
            run_id   = '0;
        end
    endtask

    task automatic check_pick(input logic hit, input logic [rsnp_pkg::ID_W-1:0] id,
                              input logic [rsnp_pkg::DIST_W-1:0] dist_sq);
        rsnp_pkg::t_result want;
        results++;
        if (expected_picks.size() == 0) begin
            report_mismatch("result with no query outstanding", 1, 0);
            return;
        end
        want = expected_picks.pop_front();
        if (want.hit_found)
            hits++;
        if (hit !== want.hit_found)
            report_mismatch("hit_found", longint'(hit), longint'(want.hit_found));
        if (id !== want.best_id)
            report_mismatch("best_id", longint'(id), longint'(want.best_id));
        if (dist_sq !== want.best_dist_sq)
            report_mismatch("best_dist_sq", longint'(dist_sq), longint'(want.best_dist_sq));
    endtask

    always @(posedge i_clk) begin : watch
        rsnp_pkg::t_item sph;
        if (!i_rst_n) begin
            ray       = '0;
            ray.dir_z = rsnp_pkg::DIR_Z_RESET;
            run_hit   = 1'b0;
            run_dist  = '0;
            run_id    = '0;
            expected_picks.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[rsnp_pkg::ADDR_W-1:2])
                    rsnp_pkg::REG_ORIGIN_X: ray.origin_x = i_pwdata[rsnp_pkg::POS_W-1:0];
                    rsnp_pkg::REG_ORIGIN_Y: ray.origin_y = i_pwdata[rsnp_pkg::POS_W-1:0];
                    rsnp_pkg::REG_ORIGIN_Z: ray.origin_z = i_pwdata[rsnp_pkg::POS_W-1:0];
                    rsnp_pkg::REG_DIR_X:    ray.dir_x    = i_pwdata[rsnp_pkg::DIR_W-1:0];
                    rsnp_pkg::REG_DIR_Y:    ray.dir_y    = i_pwdata[rsnp_pkg::DIR_W-1:0];
                    rsnp_pkg::REG_DIR_Z:    ray.dir_z    = i_pwdata[rsnp_pkg::DIR_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready)
                check_pick(i_res_user, i_res_data[15:0], i_res_data[67:16]);
            if (i_sph_valid && i_sph_ready) begin
                sph.center_x    = i_sph_data[23:0];
                sph.center_y    = i_sph_data[47:24];
                sph.center_z    = i_sph_data[71:48];
                sph.radius      = i_sph_data[94:72];
                sph.object_id   = i_sph_data[110:95];
                sph.last_sphere = i_sph_last;
                predict_sphere(sph);
            end
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - ray/sphere nearest pick testbench
// Drives sphere requests and ray settings into the pick block with random
// gaps on both streams; the checker beside the block predicts every query's
// nearest hit and scores the results. Directed spheres cover hits, misses,
// tangents, ties and field extremes, then random queries run under several
// ray settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [rsnp_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [rsnp_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int SETTLE_CYCLES   = 20;
    localparam int LONG_HOLD       = 400;
    localparam int UNIT            = 4096;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int errors, pending, results, hits;
    int spheres_sent   = 0;
    int ray_settings   = 0;
    bit calm           = 1'b0;
    bit long_hold_done = 1'b0;

    int                         ray_org [3];
    int                         ray_dir [3];
    longint                     prev_cen [3];
    logic [rsnp_pkg::RAD_W-1:0] prev_rad;
    bit                         have_prev = 1'b0;

    ray_sphere_nearest_pick_top uut (.*);

    rsnp_pick_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sph_valid (s_axis_tvalid),
        .i_sph_ready (s_axis_tready),
        .i_sph_data  (s_axis_tdata),
        .i_sph_last  (s_axis_tlast),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_user  (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_hits      (hits)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic rsnp_pkg::t_item sphere(input int cx, input int cy, input int cz,
                                               input int r, input int id, input bit last);
        rsnp_pkg::t_item s;
        s.center_x    = cx[rsnp_pkg::POS_W-1:0];
        s.center_y    = cy[rsnp_pkg::POS_W-1:0];
        s.center_z    = cz[rsnp_pkg::POS_W-1:0];
        s.radius      = r[rsnp_pkg::RAD_W-1:0];
        s.object_id   = id[rsnp_pkg::ID_W-1:0];
        s.last_sphere = last;
        return s;
    endfunction

    task automatic send_sphere(input rsnp_pkg::t_item s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, s.object_id, s.radius, s.center_z, s.center_y, s.center_x};
        s_axis_tlast  <= s.last_sphere;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        spheres_sent++;
    endtask

    task automatic write_reg(input logic [rsnp_pkg::IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    // upper data bits are noise; the registers take only their own width
    task automatic set_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz, input bit spare);
        logic [31:0] data;
        int          org [3];
        int          dir [3];
        int          k;
        org = '{ox, oy, oz};
        dir = '{dx, dy, dz};
        for (k = 0; k < 3; k++) begin
            data = $urandom;
            data[rsnp_pkg::POS_W-1:0] = org[k][rsnp_pkg::POS_W-1:0];
            write_reg(rsnp_pkg::REG_ORIGIN_X + rsnp_pkg::IDX_W'(k), data);
            ray_org[k] = int'($signed(org[k][rsnp_pkg::POS_W-1:0]));
        end
        for (k = 0; k < 3; k++) begin
            data = $urandom;
            data[rsnp_pkg::DIR_W-1:0] = dir[k][rsnp_pkg::DIR_W-1:0];
            write_reg(rsnp_pkg::REG_DIR_X + rsnp_pkg::IDX_W'(k), data);
            ray_dir[k] = int'($signed(dir[k][rsnp_pkg::DIR_W-1:0]));
        end
        if (spare) begin
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ray_settings++;
    endtask

    task automatic drain();
        int w;
        s_axis_tvalid <= 1'b0;
        for (w = 0; w < 50000 && pending != 0; w++)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // most often spheres along the ray, plus repeats for ties, spheres round
    // the origin and raw noise
    task automatic build_sphere(input bit last, output rsnp_pkg::t_item s);
        int     kind, k;
        longint t;
        longint cen [3];
        kind          = $urandom_range(0, 99);
        s.radius      = rsnp_pkg::RAD_W'($urandom);
        s.object_id   = rsnp_pkg::ID_W'($urandom);
        s.last_sphere = last;
        if (kind < 45) begin
            t = longint'($urandom_range(0, 1 << 20)) - (1 << 17);
            for (k = 0; k < 3; k++)
                cen[k] = ray_org[k] + ((ray_dir[k] * t) >>> 12)
                       + int'($urandom_range(0, 1 << 15)) - (1 << 14);
            s.radius = rsnp_pkg::RAD_W'($urandom_range(0, 1 << 15));
        end else if (kind < 60 && have_prev) begin
            cen = prev_cen;
            if ($urandom_range(0, 1))
                s.radius = prev_rad;
        end else if (kind < 75) begin
            for (k = 0; k < 3; k++)
                cen[k] = ray_org[k] + int'($urandom_range(0, 1 << 16)) - (1 << 15);
            s.radius = rsnp_pkg::RAD_W'($urandom_range(1 << 14, 1 << 18));
        end else begin
            for (k = 0; k < 3; k++)
                cen[k] = longint'($signed($urandom));
        end
        s.center_x = cen[0][rsnp_pkg::POS_W-1:0];
        s.center_y = cen[1][rsnp_pkg::POS_W-1:0];
        s.center_z = cen[2][rsnp_pkg::POS_W-1:0];
        prev_cen   = cen;
        prev_rad   = s.radius;
        have_prev  = 1'b1;
    endtask

    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && results >= 40) begin
                // hold the results off so the block fills and stalls spheres
                long_hold_done = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        rsnp_pkg::t_item s;
        int              p, n, dx, dy, dz, ymax;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        ray_org       = '{0, 0, 0};
        ray_dir       = '{0, 0, UNIT};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sphere(sphere(0, 0, 10 * UNIT, UNIT, 1, 1'b1));
        send_sphere(sphere(5 * UNIT, 0, 10 * UNIT, UNIT, 2, 1'b1));
        send_sphere(sphere(0, 0, -10 * UNIT, UNIT, 3, 1'b1));
        send_sphere(sphere(0, 0, -UNIT, 2 * UNIT, 4, 1'b1));
        send_sphere(sphere(UNIT, 0, 10 * UNIT, UNIT, 5, 1'b1));
        send_sphere(sphere(0, 0, 0, 0, 0, 1'b1));
        send_sphere(sphere(0, 0, 20 * UNIT, UNIT, 7, 1'b0));
        send_sphere(sphere(0, 0, 20 * UNIT, 2 * UNIT, 9, 1'b0));
        send_sphere(sphere(10 * UNIT, 10 * UNIT, 0, UNIT, 11, 1'b1));
        send_sphere(sphere(0, 0, 5 * UNIT, UNIT, 20, 1'b0));
        send_sphere(sphere(0, 0, 15 * UNIT, UNIT, 21, 1'b0));
        send_sphere(sphere(0, 0, 25 * UNIT, 1, 22, 1'b1));
        send_sphere(sphere(100 * UNIT, 0, 0, UNIT, 30, 1'b0));
        send_sphere(sphere(-100 * UNIT, 0, 0, UNIT, 31, 1'b1));
        send_sphere(sphere(8388607, 8388607, 8388607, 8388607, 65535, 1'b1));
        send_sphere(sphere(-8388608, -8388608, -8388608, 8388607, 65535, 1'b1));
        send_sphere(sphere(8388607, -8388608, 8388607, 0, 0, 1'b1));
        send_sphere(sphere(0, 0, 8388607, 8388607, 65535, 1'b1));
        send_sphere(sphere(-8388608, 0, 0, 8388607, 16'h5a5a, 1'b1));

        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            calm = (p == 0 || p == 5);
            case (p)
                0: set_ray(0, 0, 0, 0, 0, UNIT, 1'b1);
                1: set_ray(8388607, 8388607, 8388607, -UNIT, 0, 0, 1'b0);
                2: set_ray(-8388608, -8388608, -8388608, 0, UNIT, 0, 1'b0);
                3: set_ray(int'($urandom_range(0, 1 << 18)) - (1 << 17),
                           int'($urandom_range(0, 1 << 18)) - (1 << 17),
                           int'($urandom_range(0, 1 << 18)) - (1 << 17),
                           -8192, 8191, -8192, 1'b0);
                default: begin
                    dx   = int'($urandom_range(0, 2 * UNIT)) - UNIT;
                    ymax = $rtoi($sqrt(16777216.0 - dx * dx));
                    dy   = int'($urandom_range(0, 2 * ymax)) - ymax;
                    dz   = $rtoi($sqrt(16777216.0 - dx * dx - dy * dy) + 0.5);
                    if ($urandom_range(0, 1))
                        dz = -dz;
                    set_ray(int'($urandom_range(0, 1 << 21)) - (1 << 20),
                            int'($urandom_range(0, 1 << 21)) - (1 << 20),
                            int'($urandom_range(0, 1 << 21)) - (1 << 20),
                            dx, dy, dz, 1'b0);
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                build_sphere(n == ITEMS_PER_PHASE - 1 || $urandom_range(0, 3) == 0, s);
                send_sphere(s);
            end
        end
        drain();

        $display("Run covered %0d sphere requests under %0d ray settings;", spheres_sent,
                 ray_settings + 1);
        $display("%0d pick results checked, %0d of them hits.", results, hits);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
